@@ sv/bscf_pkg.sv @@
// Package with the shared constants, types and register codes of the block serializer.
`timescale 1ns / 1ps

package bscf_pkg;

    localparam int ITEMS_PER_BLOCK = 8;
    localparam int ITEM_WIDTH      = 8;
    localparam int CHANNEL_STEP    = 4;

    localparam int BLOCK_W = 64;
    localparam int OUT_W   = 8;
    localparam int CNT_W   = $clog2(ITEMS_PER_BLOCK + 1);
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [BLOCK_W-1:0] ITEM_MASK =
        (ITEM_WIDTH >= BLOCK_W) ? {BLOCK_W{1'b1}} : ((BLOCK_W'(1) << ITEM_WIDTH) - BLOCK_W'(1));

    localparam logic [12:0] BPG_MAX     = 13'd4096;
    localparam logic [10:0] GC_MAX      = 11'd1024;
    localparam logic [10:0] CHANNEL_MAX = 11'd2047;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_BUDGET     = 3'd0,
        CFG_BLOCKS_PER_GROUP = 3'd1,
        CFG_GROUP_COUNT      = 3'd2,
        CFG_FIRST_CHANNEL    = 3'd3,
        CFG_CHANNEL_LIMIT    = 3'd4,
        CFG_ENABLED          = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic [CNT_W-1:0]   count;
    } t_entry;

endpackage

@@ sv/block_serializer_with_count_filter_top.sv @@
// The first item of an accepted slot is registered in the two-entry queue and then in the output register.
// One result per cycle while the output is not stalled; a slot's items leave one after another
// from the single unpacking register, which takes the next slot only when its last item is out.
// Slots of one item or none are accepted every cycle via the two-entry queue unless output stalls.
// Reset is synchronous, active low; it resets the configuration, the group state, the queue and the output valid.
`timescale 1ns / 1ps

module block_serializer_with_count_filter_top import bscf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BLOCK_W-1:0]   i_block_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_item,
    output logic                 o_last_of_slot
);

    logic   accept;
    logic   push;
    t_entry push_entry;
    logic   q_full;
    logic   q_valid;
    t_entry q_entry;
    logic   pop;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    bscf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_block_data (i_block_data),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    bscf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    bscf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_item         (o_item),
        .o_last_of_slot (o_last_of_slot)
    );

endmodule

@@ sv/bscf_front.sv @@
// Front end: configuration registers, group bookkeeping and slot classification.
`timescale 1ns / 1ps

module bscf_front import bscf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [BLOCK_W-1:0]   i_block_data,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [15:0] r_pixel_budget;
    logic [12:0] r_blocks_per_group;
    logic [10:0] r_group_count;
    logic [9:0]  r_first_channel;
    logic [10:0] r_channel_limit;
    logic        r_enabled;

    logic [11:0] r_block_position, n_block_position;
    logic [15:0] r_budget_left, n_budget_left;
    logic [10:0] r_channel_index, n_channel_index;
    logic [9:0]  r_groups_done, n_groups_done;

    logic              start_group;
    logic [10:0]       cur_channel;
    logic [15:0]       cur_budget;
    logic [CNT_W-1:0]  num_items;
    logic [12:0]       bpg;
    logic [10:0]       gc;
    logic [11:0]       stepped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_budget     <= '0;
            r_blocks_per_group <= 13'd1;
            r_group_count      <= 11'd1;
            r_first_channel    <= '0;
            r_channel_limit    <= '0;
            r_enabled          <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_BUDGET:     r_pixel_budget     <= i_cfg_data;
                CFG_BLOCKS_PER_GROUP: r_blocks_per_group <= i_cfg_data[12:0];
                CFG_GROUP_COUNT:      r_group_count      <= i_cfg_data[10:0];
                CFG_FIRST_CHANNEL:    r_first_channel    <= i_cfg_data[9:0];
                CFG_CHANNEL_LIMIT:    r_channel_limit    <= i_cfg_data[10:0];
                CFG_ENABLED:          r_enabled          <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        start_group = (r_block_position == '0);
        cur_channel = (start_group && r_groups_done == '0) ? 11'(r_first_channel)
                                                           : r_channel_index;
        cur_budget  = start_group ? r_pixel_budget : r_budget_left;
        num_items   = (cur_budget >= 16'(ITEMS_PER_BLOCK)) ? CNT_W'(ITEMS_PER_BLOCK)
                                                           : cur_budget[CNT_W-1:0];

        bpg = (r_blocks_per_group == '0) ? 13'd1 :
              (r_blocks_per_group > BPG_MAX) ? BPG_MAX : r_blocks_per_group;
        gc  = (r_group_count == '0) ? 11'd1 :
              (r_group_count > GC_MAX) ? GC_MAX : r_group_count;
        stepped = 12'(cur_channel) + 12'(CHANNEL_STEP);

        n_budget_left    = cur_budget - 16'(num_items);
        n_block_position = r_block_position + 12'd1;
        n_channel_index  = cur_channel;
        n_groups_done    = r_groups_done;
        if (13'(r_block_position) + 13'd1 >= bpg) begin
            n_block_position = '0;
            n_channel_index  = (stepped > 12'(CHANNEL_MAX)) ? CHANNEL_MAX : stepped[10:0];
            if (11'(r_groups_done) + 11'd1 >= gc) begin
                n_groups_done   = '0;
                n_channel_index = 11'(r_first_channel);
            end else begin
                n_groups_done = r_groups_done + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_position <= '0;
            r_budget_left    <= '0;
            r_channel_index  <= '0;
            r_groups_done    <= '0;
        end else if (i_accept && r_enabled) begin
            r_block_position <= n_block_position;
            r_budget_left    <= n_budget_left;
            r_channel_index  <= n_channel_index;
            r_groups_done    <= n_groups_done;
        end
    end

    assign o_push        = i_accept && r_enabled && (num_items != '0);
    assign o_entry.data  = (cur_channel < r_channel_limit) ? i_block_data : '0;
    assign o_entry.count = num_items;

`ifndef NO_ASSERTIONS
    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        13'(r_block_position) < BPG_MAX)
        else $error("Block position left the group range.");
`endif

endmodule

@@ sv/bscf_queue.sv @@
// Two-entry queue that decouples slot classification from item emission.
`timescale 1ns / 1ps

module bscf_queue import bscf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Item pushed into a full queue.");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("Queue count out of range.");
    a_pointers_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("Queue pointers disagree with the count.");
`endif

endmodule

@@ sv/bscf_back.sv @@
// Back end: unpacks queued blocks into items, one per cycle while not stalled, into an output register.
`timescale 1ns / 1ps

module bscf_back import bscf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_entry           i_q_entry,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_item,
    output logic             o_last_of_slot
);

    logic [BLOCK_W-1:0] r_data;
    logic [CNT_W-1:0]   r_left;
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_item;
    logic               r_last;
    logic               advance;

    assign advance = !r_ovalid || !i_stall;
    assign o_pop   = advance && (r_left == '0) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else if (advance) begin
            if (r_left != '0) begin
                r_left   <= r_left - CNT_W'(1);
                r_ovalid <= 1'b1;
            end else if (i_q_valid) begin
                r_left   <= i_q_entry.count - CNT_W'(1);
                r_ovalid <= 1'b1;
            end else begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_left != '0) begin
                r_item <= OUT_W'(r_data & ITEM_MASK);
                r_last <= (r_left == CNT_W'(1));
                r_data <= r_data >> ITEM_WIDTH;
            end else if (i_q_valid) begin
                r_item <= OUT_W'(i_q_entry.data & ITEM_MASK);
                r_last <= (i_q_entry.count == CNT_W'(1));
                r_data <= i_q_entry.data >> ITEM_WIDTH;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_item         = r_item;
    assign o_last_of_slot = r_last;

`ifndef NO_ASSERTIONS
    a_pending_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> r_ovalid)
        else $error("Items pending without a valid output.");
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left < CNT_W'(ITEMS_PER_BLOCK))
        else $error("Pending item count out of range.");
`endif

endmodule

@@ dv/bscf_item_checker.sv @@
// Checker that predicts the serialized items of each accepted slot and compares them with the output.
`timescale 1ns / 1ps

module bscf_item_checker import bscf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_slot_valid,
    input  logic                 i_slot_stall,
    input  logic [BLOCK_W-1:0]   i_block_data,
    input  logic                 i_item_valid,
    input  logic                 i_item_stall,
    input  logic [OUT_W-1:0]     i_item,
    input  logic                 i_last_of_slot,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0] item;
        logic             last;
    } t_slot_item;

    t_slot_item expected_items[$];

    logic [15:0] budget_reg;
    logic [12:0] bpg_reg;
    logic [10:0] gc_reg;
    logic [9:0]  first_reg;
    logic [10:0] limit_reg;
    logic        enabled_reg;

    logic [11:0] slot_pos;
    logic [15:0] budget_left;
    logic [10:0] channel;
    logic [9:0]  groups_done;

    int mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic serialize_slot(input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W-1:0] word;
        int                 n_items;
        int                 bpg;
        int                 gc;
        int                 next_channel;
        t_slot_item         res;
        if (!enabled_reg) begin
            return;
        end
        if (slot_pos == 0) begin
            if (groups_done == 0) begin
                channel = {1'b0, first_reg};
            end
            budget_left = budget_reg;
        end
        word = (channel < limit_reg) ? blk : '0;
        n_items = (budget_left < ITEMS_PER_BLOCK) ? int'(budget_left) : ITEMS_PER_BLOCK;
        for (int k = 0; k < n_items; k++) begin
            res.item = OUT_W'(word & ITEM_MASK);
            res.last = (k == n_items - 1);
            expected_items.push_back(res);
            budget_left = budget_left - 16'd1;
            word = word >> ITEM_WIDTH;
        end
        bpg = (bpg_reg == 0) ? 1 : ((bpg_reg > BPG_MAX) ? int'(BPG_MAX) : int'(bpg_reg));
        gc  = (gc_reg == 0) ? 1 : ((gc_reg > GC_MAX) ? int'(GC_MAX) : int'(gc_reg));
        if (int'(slot_pos) + 1 >= bpg) begin
            slot_pos = '0;
            next_channel = int'(channel) + CHANNEL_STEP;
            channel = (next_channel > int'(CHANNEL_MAX)) ? CHANNEL_MAX : 11'(next_channel);
            if (int'(groups_done) + 1 >= gc) begin
                groups_done = '0;
                channel = {1'b0, first_reg};
            end else begin
                groups_done = groups_done + 10'd1;
            end
        end else begin
            slot_pos = slot_pos + 12'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_item want;
        if (!i_rst_n) begin
            budget_reg  = '0;
            bpg_reg     = 13'd1;
            gc_reg      = 11'd1;
            first_reg   = '0;
            limit_reg   = '0;
            enabled_reg = 1'b0;
            slot_pos    = '0;
            budget_left = '0;
            channel     = '0;
            groups_done = '0;
            expected_items.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_BUDGET:     budget_reg  = i_cfg_data[15:0];
                    CFG_BLOCKS_PER_GROUP: bpg_reg     = i_cfg_data[12:0];
                    CFG_GROUP_COUNT:      gc_reg      = i_cfg_data[10:0];
                    CFG_FIRST_CHANNEL:    first_reg   = i_cfg_data[9:0];
                    CFG_CHANNEL_LIMIT:    limit_reg   = i_cfg_data[10:0];
                    CFG_ENABLED:          enabled_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_slot_valid && !i_slot_stall) begin
                serialize_slot(i_block_data);
            end
            if (i_item_valid && !i_item_stall) begin
                if (expected_items.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected item %02h last %0b with nothing outstanding",
                                 i_item, i_last_of_slot);
                    end
                end else begin
                    want = expected_items.pop_front();
                    if (want.item !== i_item || want.last !== i_last_of_slot) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("item mismatch: expected item %02h last %0b, got item %02h last %0b",
                                     want.item, want.last, i_item, i_last_of_slot);
                        end
                    end
                end
            end
        end
        o_pending = expected_items.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top that drives slots, configuration and output stalls and reports the verdict.
`timescale 1ns / 1ps

module tb_top;

    import bscf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_SLOTS   = 120;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 slot_valid;
    logic                 slot_stall;
    logic [BLOCK_W-1:0]   block_data;
    logic                 item_valid;
    logic                 item_stall = 1'b0;
    logic [OUT_W-1:0]     item;
    logic                 last_of_slot;

    int mismatches;
    int pending;
    int stall_run = 0;
    int quiet_cycles = 0;
    bit tx_burst = 1'b0;

    always #5 clk = ~clk;

    block_serializer_with_count_filter_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (slot_valid),
        .o_stall        (slot_stall),
        .i_block_data   (block_data),
        .o_valid        (item_valid),
        .i_stall        (item_stall),
        .o_item         (item),
        .o_last_of_slot (last_of_slot)
    );

    bscf_item_checker u_item_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_slot_valid   (slot_valid),
        .i_slot_stall   (slot_stall),
        .i_block_data   (block_data),
        .i_item_valid   (item_valid),
        .i_item_stall   (item_stall),
        .i_item         (item),
        .i_last_of_slot (last_of_slot),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 93) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [BLOCK_W-1:0] random_block();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(negedge clk) begin
        if (stall_run > 1) begin
            stall_run <= stall_run - 1;
        end else if (item_stall) begin
            item_stall <= 1'b0;
            stall_run  <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
                                                      : $urandom_range(1, 6);
        end else begin
            item_stall <= 1'b1;
            stall_run  <= idle_len();
        end
    end

    always @(posedge clk) begin
        if ((slot_valid && !slot_stall) || (item_valid && !item_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] budget, input logic [CFG_W-1:0] bpg,
                             input logic [CFG_W-1:0] gc, input logic [CFG_W-1:0] first,
                             input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] en);
        write_reg(CFG_PIXEL_BUDGET, budget);
        write_reg(CFG_BLOCKS_PER_GROUP, bpg);
        write_reg(CFG_GROUP_COUNT, gc);
        write_reg(CFG_FIRST_CHANNEL, first);
        write_reg(CFG_CHANNEL_LIMIT, limit);
        write_reg(CFG_ENABLED, en);
        cfg_we <= 1'b0;
    endtask

    task automatic send_slot(input logic [BLOCK_W-1:0] blk);
        int gap;
        bit hold;
        if ($urandom_range(0, 24) == 0) begin
            tx_burst = !tx_burst;
        end
        hold = ($urandom_range(0, 39) == 0);
        gap  = (tx_burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (hold && gap == 0) begin
            gap = 1;
        end
        if (gap > 0) begin
            slot_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            while (hold && pending != 0) @(negedge clk);
        end
        slot_valid <= 1'b1;
        block_data <= blk;
        do @(posedge clk); while (slot_stall);
        @(negedge clk);
    endtask

    // Stops sending slots and waits until the checker has no predicted item outstanding, then lets the block settle.
    task automatic drain_block();
        slot_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int          sent;
        int          phase_len;
        logic        en;
        logic [15:0] budget;
        logic [15:0] bpg;
        logic [15:0] gc;
        logic [15:0] first;
        logic [15:0] limit;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PIXEL_BUDGET;
        cfg_data   = '0;
        slot_valid = 1'b0;
        block_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The block comes out of reset disabled, and writes to unused indexes must not wake it.
        send_slot(64'h0123_4567_89AB_CDEF);
        send_slot('1);
        drain_block();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        cfg_we <= 1'b0;
        send_slot('1);
        drain_block();

        // Full budget with unused upper bits set in the written data.
        configure(16'hFFFF, 16'hE001, 16'hF801, 16'hFC00, 16'hFC00, 16'hFFFF);
        send_slot('0);
        send_slot('1);
        send_slot(64'h0123_4567_89AB_CDEF);
        send_slot(64'hAAAA_AAAA_AAAA_AAAA);
        send_slot(64'h5555_5555_5555_5555);
        send_slot(64'h8000_0000_0000_0001);
        drain_block();

        // The budget runs out inside the first slot and is reloaded for the next group.
        configure(16'd3, 16'd2, 16'd1, 16'd0, 16'd1024, 16'd1);
        send_slot(64'h1122_3344_5566_7788);
        send_slot(64'h99AA_BBCC_DDEE_FF00);
        send_slot(64'hFEDC_BA98_7654_3210);
        drain_block();

        configure(16'd0, 16'd1, 16'd1, 16'd0, 16'd1024, 16'd1);
        send_slot('1);
        drain_block();

        // Groups at or past the channel limit carry zero blocks.
        configure(16'd100, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
        send_slot('1);
        send_slot(64'hDEAD_BEEF_CAFE_F00D);
        drain_block();
        configure(16'd100, 16'd1, 16'd3, 16'd4, 16'd5, 16'd1);
        send_slot('1);
        send_slot('1);
        send_slot('1);
        drain_block();

        sent = 0;
        while (sent < RANDOM_SLOTS) begin
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 7))
                0:       budget = 16'd0;
                1:       budget = 16'hFFFF;
                default: budget = 16'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       bpg = 16'd0;
                1:       bpg = 16'd4096;
                2:       bpg = 16'd8191;
                default: bpg = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       gc = 16'd0;
                1:       gc = 16'd1024;
                2:       gc = 16'd2047;
                default: gc = 16'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 5))
                0:       first = 16'd1023;
                1:       first = 16'($urandom_range(0, 1023));
                default: first = 16'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 7))
                0:       limit = 16'd0;
                1:       limit = 16'd1024;
                2:       limit = 16'd2047;
                default: limit = 16'($urandom_range(0, 64));
            endcase
            configure(budget, bpg, gc, first, limit, 16'(($urandom << 1) | en));
            phase_len = $urandom_range(5, 30);
            repeat (phase_len) send_slot(random_block());
            if (en) begin
                sent += phase_len;
            end
            drain_block();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
